// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the tracker.
// Clock i_clk and active-low reset i_rst_n are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent must hold at the next clock.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

// Antecedent and consequent in the same clock.
`define ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checked across reset: holds at the clock after reset is sampled low.
`define ASSERT_AFTER_RST(lbl, post, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (post)) \
        else $error(msg);

`endif

// File: hdl/ltt_pkg.sv
// Shared widths, register codes and word types of the altitude target tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltt_pkg;

    localparam int FRAC_BITS  = 8;               // fraction bits of the target
    localparam int FX_W       = 32 + FRAC_BITS;  // fixed-point target width
    localparam int DIFF_W     = FX_W + 1;        // difference / working width
    localparam int GAP_W      = 14;              // gap width once below stale limit
    localparam int TC_W       = 16;
    localparam int LAG_W      = 17;
    localparam int DEN_W      = 17;              // gap + time constant
    localparam int PROD_W     = FX_W + GAP_W;    // |diff| * gap, also ALU width
    localparam int CNT_W      = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CONSTANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_GAP     = 2'd2;

    localparam logic [TC_W-1:0]  RST_TIME_CONSTANT = TC_W'(10000);
    localparam logic [LAG_W-1:0] RST_MAX_LAG       = LAG_W'(500);
    localparam logic [GAP_W-1:0] RST_STALE_GAP     = GAP_W'(500);

    typedef struct packed {
        logic [TC_W-1:0]  time_constant_ms;
        logic [LAG_W-1:0] max_lag_cm;
        logic [GAP_W-1:0] stale_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [31:0] altitude_cm;
    } t_item;

    typedef struct packed {
        logic signed [31:0] target_alt_cm;
        logic               restarted;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef struct packed {
        logic [PROD_W-1:0] a;
        logic [PROD_W-1:0] b;
        logic              sub;
    } t_alu_op;

endpackage

`default_nettype wire

// File: hdl/ltt_alu.sv
// Shared add/subtract unit of the tracker: sum or difference plus carry out.
// Depends on ltt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ltt_alu (
    input  ltt_pkg::t_alu_op           i_op,
    output logic [ltt_pkg::PROD_W-1:0] o_sum,
    output logic                       o_carry
);
    import ltt_pkg::*;

    // carry high on subtract means a >= b (unsigned)
    assign {o_carry, o_sum} = {1'b0, i_op.a}
                            + {1'b0, i_op.b ^ {PROD_W{i_op.sub}}}
                            + {{PROD_W{1'b0}}, i_op.sub};

endmodule

`default_nettype wire

// File: hdl/ltt_core.sv
// Sequencer and datapath registers of the tracker: filter step over the shared ALU.
// Depends on ltt_pkg and ltt_alu.
`timescale 1ns / 1ps
`default_nettype none

module ltt_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ltt_pkg::t_item       i_item,
    input  ltt_pkg::t_cfg        i_cfg,
    input  logic                 i_out_free,
    output ltt_pkg::t_core_stat  o_stat,
    output ltt_pkg::t_result     o_res
);
    import ltt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MAG, S_MUL, S_DIV, S_APPLY, S_CLAMP, S_SAT, S_DONE
    } t_state;

    localparam logic [FX_W-1:0] FRAC_MASK = FX_W'((64'd1 << FRAC_BITS) - 64'd1);

    t_state                   r_state;
    logic signed [FX_W-1:0]   r_target;
    logic [31:0]              r_last_time;
    logic                     r_have_last;
    logic signed [FX_W-1:0]   r_alt_fx;
    logic                     r_restart;
    logic [GAP_W-1:0]         r_gap;
    logic [DEN_W-1:0]         r_den;
    logic                     r_neg;
    logic [FX_W-1:0]          r_mag;
    logic [PROD_W-1:0]        r_acc;
    logic [DEN_W:0]           r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DIFF_W-1:0] r_t;

    t_alu_op                  alu_op;
    logic [PROD_W-1:0]        alu_sum;
    logic                     alu_carry;

    logic [31:0]              gap_full;
    logic                     restart;
    logic signed [FX_W-1:0]   alt_fx_in;
    logic [DEN_W:0]           rem_sh;
    logic signed [DIFF_W-1:0] lag_fx;
    logic signed [DIFF_W-1:0] lo;
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] clamped;
    logic signed [FX_W-1:0]   saturated;
    logic signed [FX_W-1:0]   t_shift;
    logic                     round_up;

    ltt_alu u_alu (
        .i_op    (alu_op),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    assign gap_full  = i_item.now_ms - r_last_time;
    assign restart   = !r_have_last || (gap_full > 32'(i_cfg.stale_gap_ms));
    assign alt_fx_in = FX_W'(i_item.altitude_cm) <<< FRAC_BITS;
    assign rem_sh    = {r_rem[DEN_W-1:0], r_acc[PROD_W-1]};

    // clamp window around the altitude
    assign lag_fx  = $signed(DIFF_W'(i_cfg.max_lag_cm) << FRAC_BITS);
    assign lo      = DIFF_W'(r_alt_fx) - lag_fx;
    assign hi      = DIFF_W'(r_alt_fx) + lag_fx;
    assign clamped = (r_t < lo) ? lo : ((r_t > hi) ? hi : r_t);

    // saturate to the FX_W range
    assign saturated = (r_t[DIFF_W-1] != r_t[FX_W-1])
                     ? {r_t[DIFF_W-1], {(FX_W-1){~r_t[DIFF_W-1]}}}
                     : r_t[FX_W-1:0];

    // truncate toward zero to whole centimetres
    assign t_shift  = r_target >>> FRAC_BITS;
    assign round_up = r_target[FX_W-1] && ((r_target & FRAC_MASK) != '0);

    assign o_res.target_alt_cm = $signed(t_shift[31:0] + 32'(round_up));
    assign o_res.restarted     = r_restart;
    assign o_stat.idle         = (r_state == S_IDLE);
    assign o_stat.done         = (r_state == S_DONE);

    always_comb begin
        alu_op = '0;
        case (r_state)
            S_DIFF: begin
                alu_op.a   = PROD_W'(r_alt_fx);
                alu_op.b   = PROD_W'(r_target);
                alu_op.sub = 1'b1;
            end
            S_MAG: begin
                alu_op.b   = r_acc;
                alu_op.sub = 1'b1;
            end
            S_MUL: begin
                alu_op.a = {r_acc[PROD_W-2:0], 1'b0};
                alu_op.b = r_gap[GAP_W-1] ? PROD_W'(r_mag) : '0;
            end
            S_DIV: begin
                alu_op.a   = PROD_W'(rem_sh);
                alu_op.b   = PROD_W'(r_den);
                alu_op.sub = 1'b1;
            end
            S_APPLY: begin
                alu_op.a   = PROD_W'(r_t);
                alu_op.b   = PROD_W'(r_acc[FX_W-1:0]);
                alu_op.sub = r_neg;
            end
            default: alu_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_target    <= '0;
            r_last_time <= '0;
            r_have_last <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_alt_fx    <= alt_fx_in;
                        r_last_time <= i_item.now_ms;
                        r_have_last <= 1'b1;
                        r_gap       <= gap_full[GAP_W-1:0];
                        r_den       <= DEN_W'(gap_full[GAP_W-1:0])
                                     + DEN_W'(i_cfg.time_constant_ms);
                        r_restart   <= restart;
                        r_cnt       <= '0;
                        if (restart) begin
                            r_t     <= DIFF_W'(alt_fx_in);
                            r_state <= S_CLAMP;
                        end else if (gap_full == '0) begin
                            // no time passed: target stays put
                            r_t     <= DIFF_W'(r_target);
                            r_state <= S_CLAMP;
                        end else begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_acc   <= alu_sum;
                    r_neg   <= alu_sum[DIFF_W-1];
                    r_t     <= DIFF_W'(r_target);
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_mag   <= r_neg ? alu_sum[FX_W-1:0] : r_acc[FX_W-1:0];
                    r_acc   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // shift-add, gap MSB first
                    r_acc <= alu_sum;
                    r_gap <= {r_gap[GAP_W-2:0], 1'b0};
                    if (r_cnt == CNT_W'(GAP_W - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIV: begin
                    // restoring divide, quotient shifts into r_acc
                    r_rem <= alu_carry ? alu_sum[DEN_W:0] : rem_sh;
                    r_acc <= {r_acc[PROD_W-2:0], alu_carry};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(PROD_W - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_t     <= alu_sum[DIFF_W-1:0];
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_t     <= clamped;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_target <= saturated;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/lagged_altitude_target_tracker.sv
// Lagged altitude target tracker: configuration registers, handshakes, output word register.
// Depends on ltt_pkg and ltt_core (which holds ltt_alu).
`timescale 1ns / 1ps
`default_nettype none

// Each active input word (timestamp in ms, altitude in cm) moves a fixed-point
// target (8 fraction bits) toward the altitude by diff*gap/(gap+time_constant),
// clamps it to within max_lag_cm of the altitude and returns it in whole
// centimetres, truncated toward zero. The first word, or a gap above
// stale_gap_ms, restarts the target at the altitude and sets restarted.
// Inactive words are taken and dropped with no result. A filtering word runs a
// shift-add multiply and a restoring divide on the one shared adder, plus
// acceptance, set-up, apply, clamp, saturate and hand-off. A restart, or a zero
// gap, skips the multiply and divide. The next word is taken in the cycle after
// the result lands in the output register, so a result may still wait there
// while the next word runs. Configuration writes are always accepted; write
// them only while the block is idle.
module lagged_altitude_target_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_active,
    input  logic [31:0]                       i_now_ms,
    input  logic signed [31:0]                i_altitude_cm,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [31:0]                o_target_alt_cm,
    output logic                              o_restarted,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ltt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ltt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ltt_pkg::*;

    t_cfg       r_cfg;
    logic       r_out_valid;
    t_result    r_out;

    t_item      item;
    t_core_stat stat;
    t_result    res;
    logic       start;
    logic       out_free;

    assign item.now_ms      = i_now_ms;
    assign item.altitude_cm = i_altitude_cm;

    assign o_in_ready  = stat.idle;
    assign start       = i_in_valid && o_in_ready && i_active;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_target_alt_cm = r_out.target_alt_cm;
    assign o_restarted     = r_out.restarted;

    ltt_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (item),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_stat     (stat),
        .o_res      (res)
    );

    // configuration registers; unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_constant_ms <= RST_TIME_CONSTANT;
            r_cfg.max_lag_cm       <= RST_MAX_LAG;
            r_cfg.stale_gap_ms     <= RST_STALE_GAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIME_CONSTANT: r_cfg.time_constant_ms <= i_cfg_data[TC_W-1:0];
                CFG_MAX_LAG:       r_cfg.max_lag_cm       <= i_cfg_data[LAG_W-1:0];
                CFG_STALE_GAP:     r_cfg.stale_gap_ms     <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done && out_free) begin
            r_out_valid <= 1'b1;
            r_out       <= res;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ltt_checker.sv
// Port-level checker for the altitude target tracker, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ltt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              o_in_ready,
    input  logic                              i_active,
    input  logic                              o_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [31:0]                o_target_alt_cm,
    input  logic                              o_restarted
);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_target_alt_cm) && $stable(o_restarted), "result word changed while stalled")

    // reset empties the output register
    `ASSERT_AFTER_RST(a_rst_empty, !o_out_valid, "result word valid after reset")

    // an active word keeps the block busy for at least the next cycle
    `ASSERT_NEXT(a_busy_after_take, i_in_valid && o_in_ready && i_active, !o_in_ready, "ready stayed high after an active word")

    // an inactive word gives no result
    `ASSERT_NEXT(a_skip_silent, i_in_valid && o_in_ready && !i_active && !o_out_valid, !o_out_valid, "result from an inactive word")

    // a result only appears after a busy cycle
    `ASSERT_SAME(a_result_from_work, $rose(o_out_valid), $past(!o_in_ready), "result without work")

endmodule

bind lagged_altitude_target_tracker ltt_checker u_ltt_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the lagged altitude target tracker: a directed table, then randomised phases,
// with a cycle-free fixed-point lag filter predictor or typed table results checking each result word.
// Depends on ltt_pkg and lagged_altitude_target_tracker.

module testbench;

    import ltt_pkg::*;

    localparam int DIRECTED_ROWS = 18;
    localparam int PHASE_COUNT   = 7;
    localparam int PHASE_WORDS   = 255;     // active random words per phase
    localparam int DRAIN_CYCLES  = 100;     // quiet cycles once every result is back
    localparam int TIMEOUT_NS    = 16_000_000;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint FX_ONE = longint'(1) << FRAC_BITS;
    localparam longint FX_MIN = -(longint'(1) << 31) * FX_ONE;
    localparam longint FX_MAX = ((longint'(1) << 31) - 1) * FX_ONE + FX_ONE - 1;

    // directed row: input word, and where chk is set the result typed in by hand
    typedef struct packed {
        logic               act;
        logic [31:0]        now;
        logic signed [31:0] alt;
        logic               chk;
        logic signed [31:0] tgt;
        logic               rst;
    } t_row;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] tc;
        logic [CFG_DATA_W-1:0] lag;
        logic [CFG_DATA_W-1:0] stale;
        int                    in_pct;
        int                    out_pct;
        logic                  pressure;
        logic                  probe;   // also write the unused index
    } t_phase;

    // Reset settings throughout: time constant 10000, lag 500, stale 500.
    localparam t_row PLAN [DIRECTED_ROWS] = '{
        '{1'b0, 32'd123,        32'sd5000,       1'b0, 32'sd0,          1'b0}, // skipped
        '{1'b1, 32'd1000,       32'sd100000,     1'b1, 32'sd100000,     1'b1}, // first word
        '{1'b1, 32'd1100,       32'sd100000,     1'b1, 32'sd100000,     1'b0}, // no difference
        '{1'b1, 32'd1600,       32'sd101000,     1'b1, 32'sd100500,     1'b0}, // gap at limit, lag clamp
        '{1'b1, 32'd2101,       32'sd7,          1'b1, 32'sd7,          1'b1}, // gap one past limit
        '{1'b1, 32'd2101,       -32'sd200,       1'b1, 32'sd7,          1'b0}, // zero gap, no move
        '{1'b0, 32'd0,          -32'sd1,         1'b0, 32'sd0,          1'b0},
        '{1'b1, 32'd2200,       -32'sd200,       1'b0, 32'sd0,          1'b0},
        '{1'b1, 32'hFFFF_FF00,  32'sh7FFF_FFFF,  1'b1, 32'sh7FFF_FFFF,  1'b1}, // top altitude
        '{1'b1, 32'h0000_0010,  32'sh8000_0000,  1'b1, 32'sh8000_01F4,  1'b0}, // wrap, full swing
        '{1'b1, 32'h0000_0020,  32'sh7FFF_FFFF,  1'b1, 32'sh7FFF_FE0B,  1'b0}, // swing back
        '{1'b1, 32'd10000,      -32'sd10,        1'b1, -32'sd10,        1'b1},
        '{1'b1, 32'd10100,      -32'sd300,       1'b0, 32'sd0,          1'b0}, // negative fraction
        '{1'b1, 32'd10100,      -32'sd300,       1'b0, 32'sd0,          1'b0},
        '{1'b0, 32'hFFFF_FFFF,  32'sh7FFF_FFFF,  1'b0, 32'sd0,          1'b0},
        '{1'b1, 32'd10600,      -32'sd300,       1'b0, 32'sd0,          1'b0},
        '{1'b1, 32'd11101,      32'sd0,          1'b1, 32'sd0,          1'b1},
        '{1'b1, 32'd0,          32'sd0,          1'b1, 32'sd0,          1'b1}  // wrap restart
    };

    // tc, lag, stale, sender idle %, receiver stall %, pressure, unused index
    localparam t_phase PHASES [PHASE_COUNT] = '{
        '{17'd1000,    17'd2000,   17'd1000,  0,  0,  1'b0, 1'b0},
        '{17'd0,       17'd100,    17'd200,   81, 0,  1'b0, 1'b0},  // zero time constant
        '{17'h1_FFFF,  17'h1_FFFF, 17'd16383, 0,  81, 1'b0, 1'b0},  // tc masked to 16 bits
        '{17'd1,       17'd0,      17'd1,     26, 26, 1'b0, 1'b1},  // no lag allowed
        '{17'd60000,   17'd100000, 17'd10000, 0,  0,  1'b0, 1'b0},
        '{17'd50,      17'd300,    17'd0,     26, 26, 1'b0, 1'b0},  // every nonzero gap restarts
        '{17'd10000,   17'd500,    17'd500,   81, 81, 1'b1, 1'b0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_active = 1'b0;
    logic [31:0]           i_now_ms = '0;
    logic signed [31:0]    i_altitude_cm = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [31:0]    o_target_alt_cm;
    logic                  o_restarted;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predictor copy of the registers and state
    logic [TC_W-1:0]  m_tc = RST_TIME_CONSTANT;
    logic [LAG_W-1:0] m_lag = RST_MAX_LAG;
    logic [GAP_W-1:0] m_stale = RST_STALE_GAP;
    longint           model_target = 0;
    logic [31:0]      model_last = '0;
    logic             model_seen = 1'b0;

    t_result target_q [$];      // expected result words, oldest first
    int      mismatches = 0;
    int      in_idle_pct = 0;
    int      out_stall_pct = 0;

    // last active word sent, the base of well-formed sequences
    logic [31:0]        sim_now = '0;
    logic signed [31:0] sim_alt = '0;

    lagged_altitude_target_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_active        (i_active),
        .i_now_ms        (i_now_ms),
        .i_altitude_cm   (i_altitude_cm),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_target_alt_cm (o_target_alt_cm),
        .o_restarted     (o_restarted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

    // Next target for one accepted word; returns 0 when the word gives no result.
    function automatic bit lag_target(input logic act, input logic [31:0] now,
                                      input logic signed [31:0] alt, output t_result res);
        logic [31:0]     gap;
        longint          alt_fx;
        longint          lag_fx;
        longint          t;
        longint          diff;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        bit              restart;
        res = '0;
        if (!act)
            return 1'b0;
        alt_fx  = longint'(alt) * FX_ONE;
        gap     = now - model_last;           // wraps mod 2^32
        restart = !model_seen || gap > m_stale;
        t = model_target;
        if (restart) begin
            t = alt_fx;
        end else begin
            den  = 64'(gap) + 64'(m_tc);
            diff = alt_fx - t;
            // zero divisor (zero gap, zero tc): target stays put
            if (den != 0) begin
                mag = (diff < 0) ? -diff : diff;
                q   = (mag * 64'(gap)) / den;  // truncates toward zero on magnitude
                t   = (diff < 0) ? t - longint'(q) : t + longint'(q);
            end
        end
        lag_fx = longint'(m_lag) * FX_ONE;
        if (t < alt_fx - lag_fx)
            t = alt_fx - lag_fx;
        if (t > alt_fx + lag_fx)
            t = alt_fx + lag_fx;
        if (t < FX_MIN)
            t = FX_MIN;
        if (t > FX_MAX)
            t = FX_MAX;
        model_target = t;
        model_last   = now;
        model_seen   = 1'b1;
        res.target_alt_cm = 32'(t / FX_ONE);  // whole cm, toward zero
        res.restarted     = restart;
        return 1'b1;
    endfunction

    // Offer one word after random idle cycles; called at a clock edge, returns at acceptance.
    task automatic send_word(input logic act, input logic [31:0] now,
                             input logic signed [31:0] alt, input bit typed,
                             input t_result typed_res);
        t_result res;
        bit      got;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_active      <= act;
        i_now_ms      <= now;
        i_altitude_cm <= alt;
        do @(posedge i_clk); while (!o_in_ready);
        got = lag_target(act, now, alt, res);
        if (got)
            target_q.push_back(typed ? typed_res : res);
    endtask

    // Hold the sender off until every expected word is back, then some quiet cycles.
    task automatic wait_quiet(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (target_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TIME_CONSTANT: m_tc    = data[TC_W-1:0];
            CFG_MAX_LAG:       m_lag   = data[LAG_W-1:0];
            CFG_STALE_GAP:     m_stale = data[GAP_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly well-formed timestamp runs with drifting altitude; some noise and skipped words.
    task automatic random_words(input int count, input bit pressure);
        int                 sent;
        int                 r;
        int                 span;
        logic [31:0]        gap;
        logic               act;
        logic [31:0]        now;
        logic signed [31:0] alt;
        sent = 0;
        while (sent < count) begin
            r    = $urandom_range(99);
            act  = 1'b1;
            span = int'(m_lag) * 3 + 50;
            if (r < 6) begin
                act = 1'b0;
                now = $urandom;
                alt = $urandom;
            end else if (r < 12) begin
                now = $urandom;
                alt = $urandom;
            end else if (r < 14) begin
                // park just below the timestamp wrap so later runs cross it
                now = 32'hFFFF_FFFF - $urandom_range(40);
                alt = sim_alt;
            end else begin
                r = $urandom_range(19);
                case (r)
                    0:       gap = '0;
                    1:       gap = m_stale;
                    2:       gap = m_stale + 1;
                    3:       gap = $urandom;
                    default: gap = $urandom_range(m_stale, 1);
                endcase
                now = sim_now + gap;
                r = $urandom_range(29);
                if (r == 0)
                    alt = 32'sh7FFF_FFFF - $urandom_range(600);
                else if (r == 1)
                    alt = 32'sh8000_0000 + $urandom_range(600);
                else if (r < 6)
                    alt = sim_alt + int'($urandom_range(400000)) - 200000;
                else
                    alt = sim_alt + int'($urandom_range(2 * span)) - span;
            end
            if (act) begin
                sim_now = now;
                sim_alt = alt;
                sent++;
            end
            send_word(act, now, alt, 1'b0, '0);
            if (pressure && $urandom_range(47) == 0)
                wait_quiet(0);
        end
    endtask

    // Result side: check the word taken at this edge, then pick the next ready level.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (target_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual target %0d restarted %0b",
                         $time, o_target_alt_cm, o_restarted);
                mismatches++;
            end else begin
                want = target_q.pop_front();
                if (want.target_alt_cm !== o_target_alt_cm) begin
                    $display("%0t: target_alt_cm expected %0d, actual %0d",
                             $time, want.target_alt_cm, o_target_alt_cm);
                    mismatches++;
                end
                if (want.restarted !== o_restarted) begin
                    $display("%0t: restarted expected %0b, actual %0b",
                             $time, want.restarted, o_restarted);
                    mismatches++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        int      i;
        int      p;
        t_result typed;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words at reset settings, receiver always ready
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            typed.target_alt_cm = PLAN[i].tgt;
            typed.restarted     = PLAN[i].rst;
            send_word(PLAN[i].act, PLAN[i].now, PLAN[i].alt, PLAN[i].chk, typed);
        end
        sim_now = model_last;
        sim_alt = 32'(model_target / FX_ONE);

        for (p = 0; p < PHASE_COUNT; p++) begin
            // registers only change with the block drained
            wait_quiet(DRAIN_CYCLES);
            if (PHASES[p].probe)
                cfg_write(CFG_UNUSED, '1);
            cfg_write(CFG_TIME_CONSTANT, PHASES[p].tc);
            cfg_write(CFG_MAX_LAG, PHASES[p].lag);
            cfg_write(CFG_STALE_GAP, PHASES[p].stale);
            in_idle_pct   = PHASES[p].in_pct;
            out_stall_pct = PHASES[p].out_pct;
            random_words(PHASE_WORDS, PHASES[p].pressure);
        end

        wait_quiet(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
